// ===== hw/rtl/fpsa_pkg.sv =====
// ---------------------------------------------------------------------------
// fpsa_pkg
// Shared types, sizes and codes of the free page stack allocator.
// ---------------------------------------------------------------------------
package fpsa_pkg;

   localparam int MAX_DESCRIPTORS = 64;
   localparam int STACK_DEPTH     = 1024;

   localparam int DESC_IDX_W  = (MAX_DESCRIPTORS > 1) ? $clog2(MAX_DESCRIPTORS) : 1;
   localparam int DESC_CNT_W  = $clog2(MAX_DESCRIPTORS + 1);
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int TYPE_W   = 4;
   localparam int PAGE_W   = 52;
   localparam int PAGES_W  = 32;
   localparam int ADDR_W   = 52;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 11;
   localparam int PAGE_SHIFT = 12;

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALIGN = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TABLE = 3'd4;

   typedef struct packed {
      logic load;        // write descriptor at next table slot (loaded count)
      logic clr_used;    // clear used flags, fill and limit to depth
      logic scan_start;  // start a minimum search
      logic scan_step;   // compare entry read last cycle
      logic desc_rd;     // read descriptor at scan index
      logic pick_rd;     // read chosen descriptor
      logic take;        // latch chosen region, mark used
      logic push_page;   // push one page of the region
      logic freeze;      // limit = fill
      logic pop_rd;      // read top of stack
      logic pop;         // finish pop
      logic push_free;   // push freed address
      logic set_drop;    // note a dropped page
   } cmd_type;

   typedef struct packed {
      logic table_full;
      logic stack_empty;
      logic misaligned;
      logic at_limit;
      logic scan_last;   // scan index at last loaded entry
      logic scan_found;
      logic region_done;
      logic stack_full;  // fill reached depth
      logic no_desc;
      logic dropped;
   } sts_type;

endpackage

// ===== hw/rtl/fpsa_ram.sv =====
// ---------------------------------------------------------------------------
// fpsa_ram
// Single-port RAM, one write and one registered read per cycle; a read at the written address returns the old data.
// ---------------------------------------------------------------------------
module fpsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
endmodule

// ===== hw/rtl/fpsa_datapath.sv =====
// ---------------------------------------------------------------------------
// fpsa_datapath
// Descriptor table, usable/used flags, page stack and build search.
// ---------------------------------------------------------------------------
module fpsa_datapath import fpsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [TYPE_W-1:0]   desc_type,
   input  logic [PAGE_W-1:0]   desc_start_page,
   input  logic [PAGES_W-1:0]  desc_pages,
   input  logic [ADDR_W-1:0]   free_addr,
   output sts_type             sts,
   output logic [ADDR_W-1:0]   pop_data,
   output logic [COUNT_W-1:0]  fill_count
);
   localparam int DW = PAGE_W + PAGES_W;

   logic [DESC_CNT_W-1:0]      loaded_ff;
   logic [MAX_DESCRIPTORS-1:0] usable_ff, used_ff;
   logic [FILL_W-1:0]          fill_ff, limit_ff;
   logic [DESC_IDX_W-1:0]      scan_ff, best_idx_ff, rd_idx_ff;
   logic [PAGE_W-1:0]          best_ff, page_ff;
   logic                       found_ff, drop_ff;
   logic [PAGES_W-1:0]         left_ff;

   logic [DESC_IDX_W-1:0]      d_addr;
   logic [DW-1:0]              d_rd;
   logic [STACK_IDX_W-1:0]     s_addr;
   logic                       s_wr;
   logic [ADDR_W-1:0]          s_wdata;
   logic [PAGE_W-1:0]          rd_start;
   logic                       cand;

   assign rd_start = d_rd[DW-1 -: PAGE_W];
   assign d_addr = cmd.load ? loaded_ff[DESC_IDX_W-1:0] :
                   (cmd.pick_rd ? best_idx_ff : scan_ff);

   fpsa_ram #(.WIDTH(DW), .DEPTH(MAX_DESCRIPTORS)) u_desc (
      .clock(clock), .wr_en(cmd.load), .addr(d_addr),
      .wr_data({desc_start_page, desc_pages}), .rd_data_ff(d_rd));

   assign s_wr    = cmd.push_page | cmd.push_free;
   assign s_wdata = cmd.push_free ? free_addr :
                    {page_ff[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
   assign s_addr  = s_wr ? fill_ff[STACK_IDX_W-1:0] :
                    STACK_IDX_W'(fill_ff - FILL_W'(1));

   fpsa_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(s_wr), .addr(s_addr),
      .wr_data(s_wdata), .rd_data_ff(pop_data));

   assign cand = usable_ff[rd_idx_ff] && !used_ff[rd_idx_ff] &&
                 (!found_ff || rd_start <= best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         usable_ff <= '0;
         used_ff   <= '0;
         fill_ff   <= '0;
         limit_ff  <= '0;
      end else begin
         if (cmd.load) begin
            loaded_ff <= loaded_ff + DESC_CNT_W'(1);
            usable_ff[loaded_ff[DESC_IDX_W-1:0]] <=
               (desc_type == 4'd3) || (desc_type == 4'd4) || (desc_type == 4'd7);
            used_ff[loaded_ff[DESC_IDX_W-1:0]] <= 1'b0;
         end
         if (cmd.clr_used) begin
            used_ff  <= '0;
            fill_ff  <= '0;
            limit_ff <= FILL_W'(STACK_DEPTH);
         end
         if (cmd.take) begin
            used_ff[best_idx_ff] <= 1'b1;
         end
         if (s_wr) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end
         if (cmd.pop) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
         if (cmd.freeze) begin
            limit_ff <= fill_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_used) begin
         drop_ff <= 1'b0;
      end else if (cmd.set_drop) begin
         drop_ff <= 1'b1;
      end
      if (cmd.scan_start) begin
         scan_ff  <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.desc_rd) begin
         rd_idx_ff <= scan_ff;
         scan_ff   <= scan_ff + DESC_IDX_W'(1);
      end
      if (cmd.scan_step && cand) begin
         found_ff    <= 1'b1;
         best_ff     <= rd_start;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.take) begin
         page_ff <= rd_start;
         left_ff <= d_rd[PAGES_W-1:0];
      end
      if (cmd.push_page) begin
         page_ff <= page_ff + PAGE_W'(1);
         left_ff <= left_ff - PAGES_W'(1);
      end
   end

   assign sts.table_full  = (loaded_ff == DESC_CNT_W'(MAX_DESCRIPTORS));
   assign sts.stack_empty = (fill_ff == '0);
   assign sts.misaligned  = (free_addr[PAGE_SHIFT-1:0] != '0);
   assign sts.at_limit    = (fill_ff >= limit_ff) || (fill_ff >= FILL_W'(STACK_DEPTH));
   assign sts.scan_last   = ({1'b0, rd_idx_ff} == DESC_CNT_W'(loaded_ff - DESC_CNT_W'(1)));
   assign sts.scan_found  = found_ff;
   assign sts.region_done = (left_ff == '0);
   assign sts.stack_full  = (fill_ff == FILL_W'(STACK_DEPTH));
   assign sts.no_desc     = (loaded_ff == '0);
   assign sts.dropped     = drop_ff;
   assign fill_count      = COUNT_W'(fill_ff);
endmodule

// ===== hw/rtl/fpsa_control.sv =====
// ---------------------------------------------------------------------------
// fpsa_control
// Sequencer for load, build, alloc and free; owns the response register.
// ---------------------------------------------------------------------------
module fpsa_control import fpsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_alloc_addr,
   output logic [COUNT_W-1:0]  rsp_free_count,
   input  sts_type             sts,
   input  logic [ADDR_W-1:0]   pop_data,
   input  logic [COUNT_W-1:0]  fill_count,
   output cmd_type             cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_FIN, S_POP, S_SCAN_RD, S_SCAN_CMP, S_PICK, S_TAKE, S_PUSH, S_RESP
   } state_type;

   state_type           state_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                accept;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_alloc_addr = addr_ff;
   assign rsp_free_count = count_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_LOAD:  cmd.load = !sts.table_full;
                  OP_BUILD: begin
                     cmd.clr_used   = 1'b1;
                     cmd.scan_start = 1'b1;
                  end
                  OP_ALLOC: cmd.pop_rd = !sts.stack_empty;
                  OP_FREE:  cmd.push_free = !sts.misaligned && !sts.at_limit;
                  default: ;
               endcase
            end
         end
         S_POP:      cmd.pop = 1'b1;
         S_SCAN_RD:  begin
            cmd.desc_rd = 1'b1;
         end
         S_SCAN_CMP: cmd.scan_step = 1'b1;
         S_PICK:     cmd.pick_rd = 1'b1;
         S_TAKE:     cmd.take = 1'b1;
         S_PUSH: begin
            if (!sts.region_done) begin
               if (sts.stack_full) begin
                  cmd.set_drop = 1'b1;
               end else begin
                  cmd.push_page = 1'b1;
               end
            end
            if (sts.region_done || sts.stack_full) begin
               cmd.scan_start = 1'b1;
            end
         end
         S_RESP:     cmd.freeze = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  addr_ff <= '0;
                  case (req_op)
                     OP_LOAD: begin
                        status_ff <= sts.table_full ? ST_TABLE : ST_OK;
                        state_ff  <= S_FIN;
                     end
                     OP_BUILD: begin
                        status_ff <= ST_OK;
                        state_ff  <= sts.no_desc ? S_RESP : S_SCAN_RD;
                     end
                     OP_ALLOC: begin
                        status_ff <= sts.stack_empty ? ST_EMPTY : ST_OK;
                        state_ff  <= sts.stack_empty ? S_FIN : S_POP;
                     end
                     default: begin
                        status_ff <= sts.misaligned ? ST_ALIGN :
                                     (sts.at_limit ? ST_FULL : ST_OK);
                        state_ff  <= S_FIN;
                     end
                  endcase
               end
            end
            S_POP: begin
               addr_ff  <= pop_data;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               count_ff     <= fill_count;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_SCAN_RD:  state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (!sts.scan_last) begin
                  state_ff <= S_SCAN_RD;
               end else begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: state_ff <= sts.scan_found ? S_TAKE : S_RESP;
            S_TAKE: state_ff <= S_PUSH;
            S_PUSH: begin
               if (sts.region_done || sts.stack_full) begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_RESP: begin
               status_ff <= sts.dropped ? ST_FULL : ST_OK;
               state_ff  <= S_FIN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hw/rtl/free_page_stack_allocator.sv =====
// ---------------------------------------------------------------------------
// free_page_stack_allocator
// Page allocator over a stack of free page addresses, fed by a descriptor
// table; sequencer and datapath in separate modules.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  op, desc_*, free_addr
//   rsp      out        rsp_valid/rsp_stall  status, alloc_addr, free_count
//
// Load, free and empty alloc go through S_FIN, alloc first through S_POP
// for the registered stack read. Build runs one search pass per usable
// descriptor plus a closing pass, each scanning every loaded descriptor;
// a pass that takes a region pushes its pages until done or stack full.
// Reset is synchronous; tables need no clearing pass.
// A waiting response holds off the next transaction until it is taken.
// ---------------------------------------------------------------------------
module free_page_stack_allocator import fpsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [TYPE_W-1:0]   req_desc_type,
   input  logic [PAGE_W-1:0]   req_desc_start_page,
   input  logic [PAGES_W-1:0]  req_desc_pages,
   input  logic [ADDR_W-1:0]   req_free_addr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_alloc_addr,
   output logic [COUNT_W-1:0]  rsp_free_count
);
   cmd_type            cmd;
   sts_type            sts;
   logic [ADDR_W-1:0]  pop_data;
   logic [COUNT_W-1:0] fill_count;

   fpsa_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_alloc_addr(rsp_alloc_addr), .rsp_free_count(rsp_free_count),
      .sts(sts), .pop_data(pop_data), .fill_count(fill_count), .cmd(cmd));

   fpsa_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd),
      .desc_type(req_desc_type), .desc_start_page(req_desc_start_page),
      .desc_pages(req_desc_pages), .free_addr(req_free_addr),
      .sts(sts), .pop_data(pop_data), .fill_count(fill_count));
endmodule

// ===== sim/free_page_stack_allocator_test.sv =====
// ---------------------------------------------------------------------------
// free_page_stack_allocator_test
// Self-checking bench for the free page stack allocator. A directed table
// covers the corners: empty stack, frees before build, misaligned frees,
// address wrap, start-page ties and build overflow. A random stream of
// mostly allocs and frees then follows, with occasional loads and rebuilds.
// An internal allocator model predicts every response that the table does
// not give itself, and the bench compares each one in order while both
// sides idle and stall at varying rates.
// ---------------------------------------------------------------------------
module free_page_stack_allocator_test;
   import fpsa_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [TYPE_W-1:0]  dtype;
      logic [PAGE_W-1:0]  start;
      logic [PAGES_W-1:0] pages;
      logic [ADDR_W-1:0]  faddr;
   } req_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
      logic [COUNT_W-1:0]  count;
   } rsp_t;

   typedef struct packed {
      req_t rq;
      logic typed;
      rsp_t rs;
   } row_t;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_op;
   logic [TYPE_W-1:0]   req_desc_type;
   logic [PAGE_W-1:0]   req_desc_start_page;
   logic [PAGES_W-1:0]  req_desc_pages;
   logic [ADDR_W-1:0]   req_free_addr;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_alloc_addr;
   logic [COUNT_W-1:0]  rsp_free_count;

   free_page_stack_allocator DUT (.*);

   // allocator model state
   logic [PAGE_W-1:0]  desc_start[MAX_DESCRIPTORS];
   logic [PAGES_W-1:0] desc_pages[MAX_DESCRIPTORS];
   bit                 desc_usable[MAX_DESCRIPTORS];
   int                 desc_count;
   logic [ADDR_W-1:0]  stack_model[STACK_DEPTH];
   int                 stack_fill;
   int                 stack_limit;

   rsp_t              pending_rsp[$];
   logic [ADDR_W-1:0] handed_out[$];
   int                errors;
   int                sender_idle_pct;
   int                receiver_stall_pct;

   function automatic logic [ADDR_W-1:0] page_to_addr(input logic [PAGE_W-1:0] pg);
      return {pg[ADDR_W-PAGE_SHIFT-1:0], {PAGE_SHIFT{1'b0}}};
   endfunction

   function automatic logic [STATUS_W-1:0] rebuild_stack();
      bit                taken[MAX_DESCRIPTORS];
      bit                dropped;
      bit                found;
      int                idx;
      int                room;
      logic [PAGE_W-1:0] best;
      dropped = 0;
      stack_fill = 0;
      stack_limit = STACK_DEPTH;
      for (int i = 0; i < MAX_DESCRIPTORS; i++) taken[i] = 0;
      forever begin
         found = 0;
         idx = 0;
         best = '0;
         for (int i = 0; i < desc_count; i++) begin
            if (desc_usable[i] && !taken[i] && (!found || desc_start[i] <= best)) begin
               found = 1;
               best = desc_start[i];
               idx = i;
            end
         end
         if (!found) break;
         taken[idx] = 1;
         room = stack_limit - stack_fill;
         if (64'(desc_pages[idx]) > 64'(room)) dropped = 1;
         for (longint k = 0; k < 64'(desc_pages[idx]) && k < 64'(room); k++) begin
            stack_model[stack_fill] = page_to_addr(desc_start[idx] + PAGE_W'(k));
            stack_fill++;
         end
      end
      stack_limit = stack_fill;
      return dropped ? ST_FULL : ST_OK;
   endfunction

   function automatic rsp_t allocate_step(input req_t rq);
      rsp_t rs;
      rs.status = ST_OK;
      rs.addr = '0;
      case (rq.op)
         OP_LOAD: begin
            if (desc_count >= MAX_DESCRIPTORS) rs.status = ST_TABLE;
            else begin
               desc_start[desc_count] = rq.start;
               desc_pages[desc_count] = rq.pages;
               desc_usable[desc_count] = rq.dtype == 3 || rq.dtype == 4 || rq.dtype == 7;
               desc_count++;
            end
         end
         OP_BUILD: rs.status = rebuild_stack();
         OP_ALLOC: begin
            if (stack_fill == 0) rs.status = ST_EMPTY;
            else begin
               stack_fill--;
               rs.addr = stack_model[stack_fill];
            end
         end
         default: begin
            if (rq.faddr[PAGE_SHIFT-1:0] != 0) rs.status = ST_ALIGN;
            else if (stack_fill >= stack_limit) rs.status = ST_FULL;
            else begin
               stack_model[stack_fill] = rq.faddr;
               stack_fill++;
            end
         end
      endcase
      rs.count = COUNT_W'(stack_fill);
      return rs;
   endfunction

   function automatic logic [51:0] rand52();
      return 52'({$urandom, $urandom});
   endfunction

   function automatic req_t random_request();
      req_t rq;
      int   pick;
      int   sel;
      rq.dtype = ($urandom_range(1) == 0) ? TYPE_W'($urandom_range(15))
               : (($urandom_range(2) == 0) ? 4'd3 : ($urandom_range(1) ? 4'd4 : 4'd7));
      sel = $urandom_range(9);
      rq.start = (sel < 4) ? PAGE_W'($urandom_range(63))
               : (sel < 7) ? rand52() : {40'hFFFFFFFFFF, 12'($urandom)};
      sel = $urandom_range(99);
      rq.pages = (sel < 70) ? PAGES_W'($urandom_range(40))
               : (sel < 96) ? PAGES_W'($urandom_range(300)) : $urandom;
      rq.faddr = rand52();
      pick = $urandom_range(99);
      if (pick < 12) rq.op = OP_LOAD;
      else if (pick < 15) rq.op = OP_BUILD;
      else if (pick < 55) rq.op = OP_ALLOC;
      else begin
         rq.op = OP_FREE;
         sel = $urandom_range(3);
         if (sel < 2 && handed_out.size() > 0) begin
            rq.faddr = handed_out[$urandom_range(handed_out.size() - 1)];
         end else if (sel < 3) begin
            rq.faddr[PAGE_SHIFT-1:0] = '0;
         end
      end
      return rq;
   endfunction

   task automatic send_request(input req_t rq, input bit typed, input rsp_t typed_rsp);
      rsp_t rs;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_op = rq.op;
      req_desc_type = rq.dtype;
      req_desc_start_page = rq.start;
      req_desc_pages = rq.pages;
      req_free_addr = rq.faddr;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      rs = allocate_step(rq);
      if (typed) rs = typed_rsp;
      pending_rsp.push_back(rs);
      if (rq.op == OP_ALLOC && rs.status == ST_OK) handed_out.push_back(rs.addr);
      if (handed_out.size() > 64) void'(handed_out.pop_front());
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      rsp_t exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected transaction: status %0d alloc_addr %h free_count %0d",
                   rsp_status, rsp_alloc_addr, rsp_free_count);
            errors++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
               errors++;
            end
            if (rsp_alloc_addr !== exp_rsp.addr) begin
               $error("alloc_addr: expected %h, got %h", exp_rsp.addr, rsp_alloc_addr);
               errors++;
            end
            if (rsp_free_count !== exp_rsp.count) begin
               $error("free_count: expected %0d, got %0d", exp_rsp.count, rsp_free_count);
               errors++;
            end
         end
      end
   end

   initial begin
      #40000000;
      $display("** free_page_stack_allocator: FAILED **");
      $finish;
   end

   initial begin
      row_t directed[] = '{
         '{'{OP_ALLOC, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b1, '{ST_EMPTY, 52'd0, 11'd0}},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'h1000}, 1'b1, '{ST_FULL, 52'd0, 11'd0}},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'hF_FFFF_FFFF_FFFF}, 1'b1,
           '{ST_ALIGN, 52'd0, 11'd0}},
         '{'{OP_BUILD, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b1, '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_LOAD, 4'd3, 52'd0, 32'd2, 52'd0}, 1'b1, '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_LOAD, 4'd7, 52'hF_FFFF_FFFF_FFFF, 32'd2, 52'd0}, 1'b1,
           '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_LOAD, 4'd0, 52'd10, 32'd5, 52'd0}, 1'b1, '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_LOAD, 4'd4, 52'd0, 32'd1, 52'd0}, 1'b1, '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_LOAD, 4'd15, 52'd20, 32'd0, 52'd0}, 1'b1, '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_LOAD, 4'd3, 52'd30, 32'd0, 52'd0}, 1'b1, '{ST_OK, 52'd0, 11'd0}},
         '{'{OP_BUILD, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b0, '0},
         '{'{OP_ALLOC, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b0, '0},
         '{'{OP_ALLOC, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b0, '0},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'hA_BCDE_F012_3000}, 1'b0, '0},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'h5_4321_0FED_C000}, 1'b0, '0},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'h0_0000_0000_1000}, 1'b0, '0},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'h0_0000_0000_0800}, 1'b0, '0},
         '{'{OP_ALLOC, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b0, '0},
         '{'{OP_LOAD, 4'd3, 52'd100, 32'hFFFF_FFFF, 52'd0}, 1'b0, '0},
         '{'{OP_BUILD, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b0, '0},
         '{'{OP_ALLOC, 4'd0, 52'd0, 32'd0, 52'd0}, 1'b0, '0},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'h0_0000_0006_4000}, 1'b0, '0},
         '{'{OP_FREE, 4'd0, 52'd0, 32'd0, 52'h0_0000_0006_5000}, 1'b0, '0}
      };
      int idle_set[4] = '{0, 74, 0, 15};
      int stall_set[4] = '{0, 0, 74, 15};
      errors = 0;
      desc_count = 0;
      stack_fill = 0;
      stack_limit = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset = 1'b1;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_op = OP_LOAD;
      req_desc_type = '0;
      req_desc_start_page = '0;
      req_desc_pages = '0;
      req_free_addr = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_request(directed[i].rq, directed[i].typed, directed[i].rs);

      for (int n = 0; n < 1300; n++) begin
         sender_idle_pct = idle_set[(n / 100) % 4];
         receiver_stall_pct = stall_set[(n / 100) % 4];
         send_request(random_request(), 1'b0, '0);
      end
      req_valid = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("** free_page_stack_allocator: PASSED **");
      end else begin
         $display("** free_page_stack_allocator: FAILED **");
      end
      $finish;
   end

endmodule
